// File: hw/rtl/sfs_pkg.sv
package sfs_pkg;

    // One input word: an action and the operands that the action uses.
    typedef struct packed {
        logic [2:0] action;
        logic [15:0] elapsed;
        logic [3:0] entry_index;
        logic [7:0] entry_duration;
        logic [7:0] entry_frame;
        logic [1:0] new_mode;
    } item_t;

    // One result word: the visible play state after the action.
    typedef struct packed {
        logic [7:0] frame_out;
        logic [3:0] step_out;
        logic [1:0] mode_out;
        logic overrun;
    } result_t;

    // One step table entry as it sits in the table memory.
    typedef struct packed {
        logic [7:0] duration;
        logic [7:0] frame;
    } entry_t;

    localparam logic [2:0] ACT_TICK = 3'd0;
    localparam logic [2:0] ACT_LOAD = 3'd1;
    localparam logic [2:0] ACT_RESTART = 3'd2;
    localparam logic [2:0] ACT_SET_MODE = 3'd3;
    localparam logic [2:0] ACT_SET_FRAME = 3'd4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_ONCE = 2'd1;
    localparam logic [1:0] MODE_LOOP = 2'd2;
    localparam logic [1:0] MODE_STOPPED = 2'd3;

    localparam logic [1:0] CFG_STEP_COUNT = 2'd0;
    localparam logic [1:0] CFG_FIRST_STEP = 2'd1;
    localparam logic [1:0] CFG_SPEED = 2'd2;

    localparam logic [4:0] STEP_COUNT_RESET = 5'd1;
    localparam logic [15:0] SPEED_RESET = 16'd4096;

    localparam logic signed [31:0] TIME_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] TIME_MIN = 32'sh8000_0000;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        OP_NOP = 4'd0,
        OP_SUB = 4'd1,
        OP_ADVANCE = 4'd2,
        OP_MUL = 4'd3,
        OP_ADD = 4'd4,
        OP_EMIT = 4'd5,
        OP_FRAME_RD = 4'd6,
        OP_FRAME_LD = 4'd7,
        OP_RESTART = 4'd8,
        OP_LOAD = 4'd9,
        OP_SET_MODE = 4'd10,
        OP_SET_FRAME = 4'd11
    } op_t;

    // How the step counter moves after a control word.
    typedef enum logic [2:0] {
        SEQ_NEXT = 3'd0,
        SEQ_GOTO = 3'd1,
        SEQ_DISPATCH = 3'd2,
        SEQ_IF_NO_WALK = 3'd3,
        SEQ_IF_TICK = 3'd4
    } seq_t;

    typedef logic [3:0] upc_t;

    localparam upc_t UA_IDLE = 4'd0;
    localparam upc_t UA_SUB = 4'd1;
    localparam upc_t UA_TEST = 4'd2;
    localparam upc_t UA_MUL = 4'd3;
    localparam upc_t UA_ADD = 4'd4;
    localparam upc_t UA_EMIT = 4'd5;
    localparam upc_t UA_FRAME_RD = 4'd6;
    localparam upc_t UA_FRAME_LD = 4'd7;
    localparam upc_t UA_RESTART = 4'd8;
    localparam upc_t UA_LOAD = 4'd9;
    localparam upc_t UA_SET_MODE = 4'd10;
    localparam upc_t UA_SET_FRAME = 4'd11;

    typedef struct packed {
        op_t op;
        seq_t seq;
        upc_t target;
    } uword_t;

    // Control store. The advance walk is TEST, MUL, ADD repeated; restart
    // shares MUL and ADD and leaves ADD toward EMIT instead of TEST.
    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        w = '{op: OP_NOP, seq: SEQ_GOTO, target: UA_IDLE};
        unique case (addr)
            UA_IDLE: w = '{op: OP_NOP, seq: SEQ_DISPATCH, target: UA_IDLE};
            UA_SUB: w = '{op: OP_SUB, seq: SEQ_NEXT, target: UA_IDLE};
            UA_TEST: w = '{op: OP_ADVANCE, seq: SEQ_IF_NO_WALK, target: UA_FRAME_RD};
            UA_MUL: w = '{op: OP_MUL, seq: SEQ_NEXT, target: UA_IDLE};
            UA_ADD: w = '{op: OP_ADD, seq: SEQ_IF_TICK, target: UA_TEST};
            UA_EMIT: w = '{op: OP_EMIT, seq: SEQ_GOTO, target: UA_IDLE};
            UA_FRAME_RD: w = '{op: OP_FRAME_RD, seq: SEQ_NEXT, target: UA_IDLE};
            UA_FRAME_LD: w = '{op: OP_FRAME_LD, seq: SEQ_GOTO, target: UA_EMIT};
            UA_RESTART: w = '{op: OP_RESTART, seq: SEQ_GOTO, target: UA_MUL};
            UA_LOAD: w = '{op: OP_LOAD, seq: SEQ_GOTO, target: UA_EMIT};
            UA_SET_MODE: w = '{op: OP_SET_MODE, seq: SEQ_GOTO, target: UA_EMIT};
            UA_SET_FRAME: w = '{op: OP_SET_FRAME, seq: SEQ_GOTO, target: UA_EMIT};
            default: w = '{op: OP_NOP, seq: SEQ_GOTO, target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

// File: hw/rtl/sfs_ram.sv
// Simple dual-port RAM with one write port and a registered read port.
module sfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input logic clk,
    input logic wr_en,
    input logic [$clog2(DEPTH)-1:0] wr_addr,
    input logic [WIDTH-1:0] wr_data,
    input logic rd_en,
    input logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/sprite_frame_sequencer.sv
// Sprite animation frame sequencer. A word given on item with start high while
// busy is low is taken at that clock edge; busy then stays high until the word
// is done. Every word gives exactly one result word on result, shown for one
// cycle with result_valid high; the receiver cannot stall it, so it must take
// every result in that cycle. A new word can be given in the same cycle as the
// result strobe. A tick in once or loop mode makes one pass of the microcode walk
// for each step advance in that tick (at most MAX_ADVANCE advances): each pass
// goes through a step table read, a duration times speed multiply and a saturating
// add, all through the single read port of the step table. A restart reads its
// first step and runs the multiply and the add before its result; a tick in none
// or stopped mode and an unused action go straight to the result, and a load, a
// set mode or a set frame does its write first.
// Configuration is written on the cfg channel, which is always ready, and
// must only be written while the block is idle.
module sprite_frame_sequencer #(
    parameter int MAX_STEPS = 16,
    parameter int MAX_ADVANCE = 16
) (
    input logic clk,
    input logic rst_n,
    input logic start,
    output logic busy,
    input sfs_pkg::item_t item,
    output logic result_valid,
    output sfs_pkg::result_t result,
    input logic cfg_valid,
    output logic cfg_ready,
    input logic [1:0] cfg_index,
    input logic [15:0] cfg_data
);

    localparam int AW = $clog2(MAX_STEPS);
    localparam int NW = $clog2(MAX_ADVANCE + 1);

    // Configuration registers.
    logic [4:0] step_count_reg;
    logic [3:0] first_step_reg;
    logic [15:0] speed_reg;

    // Microcode sequencer.
    sfs_pkg::upc_t upc_reg, upc_next;
    sfs_pkg::uword_t uw;

    // Play state and working registers.
    sfs_pkg::item_t item_reg;
    logic [3:0] step_reg, step_next;
    logic signed [31:0] time_left_reg, time_left_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] shown_reg, shown_next;
    logic ovr_reg, ovr_next;
    logic [NW-1:0] walk_cnt_reg, walk_cnt_next;
    logic [23:0] prod_reg;
    logic [23:0] prod_next;
    logic result_valid_reg;
    sfs_pkg::result_t result_reg;

    // Step table port signals.
    logic tbl_wr_en;
    logic [AW-1:0] tbl_wr_addr;
    sfs_pkg::entry_t tbl_wr_data;
    logic tbl_rd_en;
    logic [AW-1:0] tbl_rd_addr;
    sfs_pkg::entry_t tbl_rd_data;

    // Datapath helpers.
    logic accept;
    logic is_tick;
    logic expired;
    logic walk;
    logic looping;
    logic [4:0] count_eff;
    logic [4:0] step_inc;
    logic wrap;
    logic [3:0] adv_step;
    logic [3:0] restart_step;
    logic load_in_range;
    logic signed [32:0] sum_add;
    logic signed [32:0] sum_sub;
    sfs_pkg::upc_t dispatch_target;

    assign uw = sfs_pkg::ucode(upc_reg);
    assign busy = (upc_reg != sfs_pkg::UA_IDLE);
    assign accept = start && !busy;
    assign cfg_ready = 1'b1;
    assign result_valid = result_valid_reg;
    assign result = result_reg;

    // The step count is clamped to the table: zero acts as one.
    always_comb
    begin
        if (step_count_reg == 5'd0)
        begin
            count_eff = 5'd1;
        end
        else if ({4'd0, step_count_reg} > 9'(MAX_STEPS))
        begin
            count_eff = 5'(MAX_STEPS);
        end
        else
        begin
            count_eff = step_count_reg;
        end
    end

    assign is_tick = (item_reg.action == sfs_pkg::ACT_TICK);
    assign expired = (time_left_reg <= 32'sd0);
    assign walk = expired && (walk_cnt_reg < NW'(MAX_ADVANCE));
    assign looping = (mode_reg == sfs_pkg::MODE_LOOP);

    // Next step of an advance: wrap to zero when looping, otherwise hold
    // the last step and stop.
    assign step_inc = {1'b0, step_reg} + 5'd1;
    assign wrap = (step_inc >= count_eff);
    assign adv_step = wrap ? (looping ? 4'd0 : step_reg) : step_inc[3:0];

    assign restart_step = ({5'd0, first_step_reg} < 9'(MAX_STEPS)) ? first_step_reg : 4'd0;
    assign load_in_range = ({5'd0, item_reg.entry_index} < 9'(MAX_STEPS));

    // Time arithmetic is done one bit wider and saturated to 32 bits. The
    // reload only adds a non-negative product and the tick only subtracts, so
    // each side can only overflow in one direction.
    assign sum_add = {time_left_reg[31], time_left_reg} + {9'd0, prod_reg};
    assign sum_sub = {time_left_reg[31], time_left_reg} - {17'd0, item_reg.elapsed};

    // Entry point for a newly accepted word.
    always_comb
    begin
        unique case (item.action)
            sfs_pkg::ACT_TICK:
            begin
                if (mode_reg == sfs_pkg::MODE_ONCE || mode_reg == sfs_pkg::MODE_LOOP)
                begin
                    dispatch_target = sfs_pkg::UA_SUB;
                end
                else
                begin
                    dispatch_target = sfs_pkg::UA_EMIT;
                end
            end
            sfs_pkg::ACT_LOAD: dispatch_target = sfs_pkg::UA_LOAD;
            sfs_pkg::ACT_RESTART: dispatch_target = sfs_pkg::UA_RESTART;
            sfs_pkg::ACT_SET_MODE: dispatch_target = sfs_pkg::UA_SET_MODE;
            sfs_pkg::ACT_SET_FRAME: dispatch_target = sfs_pkg::UA_SET_FRAME;
            default: dispatch_target = sfs_pkg::UA_EMIT;
        endcase
    end

    // Step counter.
    always_comb
    begin
        unique case (uw.seq)
            sfs_pkg::SEQ_NEXT: upc_next = upc_reg + 4'd1;
            sfs_pkg::SEQ_GOTO: upc_next = uw.target;
            sfs_pkg::SEQ_DISPATCH: upc_next = accept ? dispatch_target : upc_reg;
            sfs_pkg::SEQ_IF_NO_WALK: upc_next = walk ? (upc_reg + 4'd1) : uw.target;
            sfs_pkg::SEQ_IF_TICK: upc_next = is_tick ? uw.target : (upc_reg + 4'd1);
            default: upc_next = sfs_pkg::UA_IDLE;
        endcase
    end

    // Datapath driven by the current control word.
    always_comb
    begin
        step_next = step_reg;
        time_left_next = time_left_reg;
        mode_next = mode_reg;
        shown_next = shown_reg;
        ovr_next = ovr_reg;
        walk_cnt_next = walk_cnt_reg;
        prod_next = prod_reg;
        tbl_wr_en = 1'b0;
        tbl_wr_addr = AW'(item_reg.entry_index);
        tbl_wr_data = '{duration: item_reg.entry_duration, frame: item_reg.entry_frame};
        tbl_rd_en = 1'b0;
        tbl_rd_addr = AW'(step_reg);

        if (accept)
        begin
            ovr_next = 1'b0;
        end

        unique case (uw.op)
            sfs_pkg::OP_NOP:
            begin
            end
            sfs_pkg::OP_SUB:
            begin
                time_left_next = (sum_sub[32:31] == 2'b10) ? sfs_pkg::TIME_MIN : sum_sub[31:0];
                walk_cnt_next = '0;
            end
            sfs_pkg::OP_ADVANCE:
            begin
                if (walk)
                begin
                    step_next = adv_step;
                    if (wrap && !looping)
                    begin
                        mode_next = sfs_pkg::MODE_STOPPED;
                    end
                    walk_cnt_next = walk_cnt_reg + NW'(1);
                    tbl_rd_en = 1'b1;
                    tbl_rd_addr = AW'(adv_step);
                end
            end
            sfs_pkg::OP_MUL:
            begin
                prod_next = {16'd0, tbl_rd_data.duration} * {8'd0, speed_reg};
            end
            sfs_pkg::OP_ADD:
            begin
                time_left_next = (sum_add[32:31] == 2'b01) ? sfs_pkg::TIME_MAX : sum_add[31:0];
            end
            sfs_pkg::OP_EMIT:
            begin
            end
            sfs_pkg::OP_FRAME_RD:
            begin
                tbl_rd_en = 1'b1;
            end
            sfs_pkg::OP_FRAME_LD:
            begin
                shown_next = tbl_rd_data.frame;
                ovr_next = expired;
            end
            sfs_pkg::OP_RESTART:
            begin
                step_next = restart_step;
                tbl_rd_en = 1'b1;
                tbl_rd_addr = AW'(restart_step);
            end
            sfs_pkg::OP_LOAD:
            begin
                tbl_wr_en = load_in_range;
            end
            sfs_pkg::OP_SET_MODE:
            begin
                mode_next = item_reg.new_mode;
            end
            sfs_pkg::OP_SET_FRAME:
            begin
                shown_next = item_reg.entry_frame;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= sfs_pkg::UA_IDLE;
            step_reg <= 4'd0;
            time_left_reg <= 32'sd0;
            mode_reg <= sfs_pkg::MODE_NONE;
            shown_reg <= 8'd0;
            ovr_reg <= 1'b0;
            walk_cnt_reg <= '0;
            result_valid_reg <= 1'b0;
            step_count_reg <= sfs_pkg::STEP_COUNT_RESET;
            first_step_reg <= 4'd0;
            speed_reg <= sfs_pkg::SPEED_RESET;
        end
        else
        begin
            upc_reg <= upc_next;
            step_reg <= step_next;
            time_left_reg <= time_left_next;
            mode_reg <= mode_next;
            shown_reg <= shown_next;
            ovr_reg <= ovr_next;
            walk_cnt_reg <= walk_cnt_next;
            result_valid_reg <= (uw.op == sfs_pkg::OP_EMIT);
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    sfs_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_data[4:0];
                    sfs_pkg::CFG_FIRST_STEP: first_step_reg <= cfg_data[3:0];
                    sfs_pkg::CFG_SPEED: speed_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers: the captured word, the product and the result.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        prod_reg <= prod_next;
        if (uw.op == sfs_pkg::OP_EMIT)
        begin
            result_reg <= '{frame_out: shown_reg, step_out: step_reg,
                            mode_out: mode_reg, overrun: ovr_reg};
        end
    end

    // Step table: duration and frame of each step side by side.
    sfs_ram #(
        .WIDTH($bits(sfs_pkg::entry_t)),
        .DEPTH(MAX_STEPS)
    ) u_step_table (
        .clk(clk),
        .wr_en(tbl_wr_en),
        .wr_addr(tbl_wr_addr),
        .wr_data(tbl_wr_data),
        .rd_en(tbl_rd_en),
        .rd_addr(tbl_rd_addr),
        .rd_data(tbl_rd_data)
    );

endmodule

// File: test/tb_sprite_frame_sequencer.sv
module tb_sprite_frame_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    import sfs_pkg::*;

    // Table size and advance cap of the instance under test.
    localparam int STEP_SLOTS = 16;
    localparam int ADVANCE_CAP = 16;

    // Action codes that the block treats as no operation.
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_LAST = 3'd7;

    // The configuration channel carries a two bit index, so one index names no register.
    localparam logic [1:0] CFG_NO_REG = 2'd3;

    // Cycles allowed after the last result word before the block counts as idle.
    localparam int SETTLE_CYCLES = 4;
    // Cycles allowed for the whole run before it is declared hung.
    localparam int CYCLE_LIMIT = 1000000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    item_t item;
    logic result_valid;
    result_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    sprite_frame_sequencer #(
        .MAX_STEPS(STEP_SLOTS),
        .MAX_ADVANCE(ADVANCE_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .result_valid(result_valid),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // One row of the directed part. When typed is set the expected word is the one
    // written in the row; otherwise it comes from the play state tracker below.
    typedef struct {
        item_t word;
        bit typed;
        result_t want;
    } directed_row_t;

    directed_row_t directed_rows[$];

    // Play state words still owed by the block, oldest first.
    result_t expected_play_states[$];

    int mismatch_count;
    int cycle_count;
    bit no_idle;

    // Shadow copy of the block state, kept in step with every accepted word.
    logic [7:0] dur_table [STEP_SLOTS];
    logic [7:0] frame_table [STEP_SLOTS];
    logic [3:0] cur_step_q;
    longint time_left_q;
    logic [1:0] mode_q;
    logic [7:0] shown_frame_q;

    // Shadow copy of the configuration registers.
    logic [4:0] step_count_q;
    logic [3:0] first_step_q;
    logic [15:0] speed_q;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Remaining time lives in a signed 32 bit register, so every sum saturates.
    function automatic longint clamp_time(input longint v);
        if (v > longint'(TIME_MAX))
            return longint'(TIME_MAX);
        if (v < longint'(TIME_MIN))
            return longint'(TIME_MIN);
        return v;
    endfunction

    // Adds the current step's duration, scaled by the speed, to the remaining time.
    function automatic void reload_step_time();
        longint dur;
        longint spd;
        dur = dur_table[cur_step_q];
        spd = speed_q;
        time_left_q = clamp_time(time_left_q + dur * spd);
    endfunction

    // Applies one accepted word to the shadow state and returns the play state word
    // that the block must report for it.
    function automatic result_t next_play_state(input item_t w);
        result_t r;
        int unsigned count;
        int unsigned nxt;
        int unsigned walks;
        bit looping;
        longint el;
        r.overrun = 1'b0;
        case (w.action)
            ACT_TICK:
            begin
                // Ticks only move time in once and loop modes.
                if (mode_q == MODE_ONCE || mode_q == MODE_LOOP)
                begin
                    count = step_count_q;
                    if (count == 0)
                        count = 1;
                    if (count > STEP_SLOTS)
                        count = STEP_SLOTS;
                    looping = (mode_q == MODE_LOOP);
                    el = w.elapsed;
                    time_left_q = clamp_time(time_left_q - el);
                    walks = 0;
                    while (time_left_q <= 0 && walks < ADVANCE_CAP)
                    begin
                        nxt = int'(cur_step_q) + 1;
                        if (nxt >= count)
                        begin
                            // Loop wraps to the first slot; once holds the step and
                            // stops, but the walk goes on reloading the held step.
                            if (looping)
                                nxt = 0;
                            else
                            begin
                                nxt = cur_step_q;
                                mode_q = MODE_STOPPED;
                            end
                        end
                        cur_step_q = nxt[3:0];
                        reload_step_time();
                        walks++;
                    end
                    shown_frame_q = frame_table[cur_step_q];
                    r.overrun = (time_left_q <= 0);
                end
            end
            ACT_LOAD:
            begin
                dur_table[w.entry_index] = w.entry_duration;
                frame_table[w.entry_index] = w.entry_frame;
            end
            ACT_RESTART:
            begin
                cur_step_q = first_step_q;
                reload_step_time();
            end
            ACT_SET_MODE:
                mode_q = w.new_mode;
            ACT_SET_FRAME:
                shown_frame_q = w.entry_frame;
            default:
            begin
            end
        endcase
        r.frame_out = shown_frame_q;
        r.step_out = cur_step_q;
        r.mode_out = mode_q;
        return r;
    endfunction

    function automatic item_t word_of(input logic [2:0] act, input logic [15:0] el,
                                      input logic [3:0] idx, input logic [7:0] dur,
                                      input logic [7:0] frm, input logic [1:0] md);
        item_t w;
        w.action = act;
        w.elapsed = el;
        w.entry_index = idx;
        w.entry_duration = dur;
        w.entry_frame = frm;
        w.new_mode = md;
        return w;
    endfunction

    function automatic result_t state_of(input logic [7:0] frm, input logic [3:0] stp,
                                         input logic [1:0] md, input logic ovr);
        result_t r;
        r.frame_out = frm;
        r.step_out = stp;
        r.mode_out = md;
        r.overrun = ovr;
        return r;
    endfunction

    function automatic void add_row(input item_t w, input bit typed, input result_t want);
        directed_row_t row;
        row.word = w;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // Presents one word after an optional gap and holds it until the block takes it.
    // With no gap, start stays high and the next word follows straight on, so the
    // block also sees start high while it is still busy with the previous word.
    task automatic send_word(input item_t w, input bit typed, input result_t want);
        int gap;
        int gap_pick;
        logic [31:0] junk;
        result_t predicted;
        gap = 0;
        if (!no_idle)
        begin
            gap_pick = $urandom_range(0, 99);
            if (gap_pick < 60)
                gap = 0;
            else if (gap_pick < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(8, 40);
        end
        if (gap > 0)
        begin
            // Garbage on the item bus while start is low must be ignored.
            junk = $urandom;
            start <= 1'b0;
            item <= item_t'({junk, junk[8:0]});
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (busy);
        predicted = next_play_state(w);
        expected_play_states.push_back(typed ? want : predicted);
    endtask

    // Lowers start and waits until every owed word has come back.
    task automatic wait_drained();
        start <= 1'b0;
        while (expected_play_states.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_STEP_COUNT:
                step_count_q = data[4:0];
            CFG_FIRST_STEP:
                first_step_q = data[3:0];
            CFG_SPEED:
                speed_q = data;
            default:
            begin
            end
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Registers are only written once the block has gone quiet.
    task automatic program_regs(input logic [15:0] count_data, input logic [15:0] first_data,
                                input logic [15:0] speed_data);
        wait_drained();
        write_cfg(CFG_STEP_COUNT, count_data);
        write_cfg(CFG_FIRST_STEP, first_data);
        write_cfg(CFG_SPEED, speed_data);
    endtask

    // Random words, weighted toward ticks in the playing modes so that the advance
    // walk, the once-mode stop and the overrun cap are reached often. All fields
    // carry random bits whatever the action, so unused operands toggle too.
    task automatic run_random_phase(input int n_words);
        item_t w;
        logic [31:0] r1;
        logic [31:0] r2;
        int pick;
        for (int k = 0; k < n_words; k++)
        begin
            r1 = $urandom;
            r2 = $urandom;
            w.action = r1[2:0];
            w.elapsed = r1[18:3];
            w.entry_index = r1[22:19];
            w.entry_duration = r1[30:23];
            w.entry_frame = r2[7:0];
            w.new_mode = r2[9:8];
            pick = $urandom_range(0, 99);
            if (pick < 50)
                w.action = ACT_TICK;
            else if (pick < 60)
                w.action = ACT_LOAD;
            else if (pick < 70)
                w.action = ACT_RESTART;
            else if (pick < 84)
                w.action = ACT_SET_MODE;
            else if (pick < 95)
                w.action = ACT_SET_FRAME;
            // Elapsed time is most often a few frames so that steps advance one or two
            // at a time, with zero, full scale and raw random values mixed in.
            pick = $urandom_range(0, 99);
            if (pick < 45)
                w.elapsed = {3'b000, r2[24:12]};
            else if (pick < 55)
                w.elapsed = 16'h0000;
            else if (pick < 62)
                w.elapsed = 16'hFFFF;
            if ($urandom_range(0, 99) < 85)
                w.new_mode = r2[25] ? MODE_LOOP : MODE_ONCE;
            // Zero durations feed the overrun cap; short ones keep the walk busy.
            pick = $urandom_range(0, 99);
            if (pick < 15)
                w.entry_duration = 8'h00;
            else if (pick < 65)
                w.entry_duration = {5'd0, r2[28:26]} + 8'd1;
            send_word(w, 1'b0, '0);
        end
    endtask

    // Every result word is taken in its strobe cycle and compared with the oldest
    // expected play state.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_play_states.size() == 0)
            begin
                $display("%0t: result word with nothing expected, got %h", $time, result);
                mismatch_count++;
            end
            else
            begin
                want = expected_play_states.pop_front();
                if (result.frame_out !== want.frame_out)
                begin
                    $display("%0t: frame_out expected %h got %h", $time,
                             want.frame_out, result.frame_out);
                    mismatch_count++;
                end
                if (result.step_out !== want.step_out)
                begin
                    $display("%0t: step_out expected %h got %h", $time,
                             want.step_out, result.step_out);
                    mismatch_count++;
                end
                if (result.mode_out !== want.mode_out)
                begin
                    $display("%0t: mode_out expected %h got %h", $time,
                             want.mode_out, result.mode_out);
                    mismatch_count++;
                end
                if (result.overrun !== want.overrun)
                begin
                    $display("%0t: overrun expected %b got %b", $time,
                             want.overrun, result.overrun);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_sprite_frame_sequencer: errors");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] slot_dur;
        logic [31:0] rnd;
        start <= 1'b0;
        item <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_STEP_COUNT;
        cfg_data <= '0;
        rst_n <= 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        no_idle = 1'b0;

        // Shadow state after reset. The tables start unknown; they are filled below
        // before any action can read them.
        for (int i = 0; i < STEP_SLOTS; i++)
        begin
            dur_table[i] = 8'h00;
            frame_table[i] = 8'h00;
        end
        cur_step_q = 4'd0;
        time_left_q = 0;
        mode_q = MODE_NONE;
        shown_frame_q = 8'h00;
        step_count_q = STEP_COUNT_RESET;
        first_step_q = 4'd0;
        speed_q = SPEED_RESET;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every slot so no later step read hits an unwritten entry. A few
        // slots get zero duration and one the full scale duration.
        for (int i = 0; i < STEP_SLOTS; i++)
        begin
            if (i == 2)
                slot_dur = 8'hFF;
            else if (i == 1 || i == 5)
                slot_dur = 8'h00;
            else
                slot_dur = 8'(i % 4 + 1);
            send_word(word_of(ACT_LOAD, 16'h0000, i[3:0], slot_dur, 8'(i * 17), MODE_NONE),
                      1'b0, '0);
        end

        // Directed part, still with the reset configuration: one active step,
        // restart at slot zero, unit speed.
        // A tick in none mode leaves the reset state alone.
        add_row(word_of(ACT_TICK, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, MODE_STOPPED), 1'b1,
                state_of(8'h00, 4'd0, MODE_NONE, 1'b0));
        // Spare actions only report the state.
        add_row(word_of(ACT_SPARE_LAST, 16'hFFFF, 4'hF, 8'hFF, 8'hFF, MODE_STOPPED), 1'b1,
                state_of(8'h00, 4'd0, MODE_NONE, 1'b0));
        add_row(word_of(ACT_SPARE_FIRST, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b1,
                state_of(8'h00, 4'd0, MODE_NONE, 1'b0));
        add_row(word_of(ACT_SET_FRAME, 16'h0000, 4'h0, 8'h00, 8'hFF, MODE_NONE), 1'b1,
                state_of(8'hFF, 4'd0, MODE_NONE, 1'b0));
        add_row(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_STOPPED), 1'b1,
                state_of(8'hFF, 4'd0, MODE_STOPPED, 1'b0));
        // Stopped mode ignores ticks as well.
        add_row(word_of(ACT_TICK, 16'h1000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b1,
                state_of(8'hFF, 4'd0, MODE_STOPPED, 1'b0));
        add_row(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b1,
                state_of(8'hFF, 4'd0, MODE_NONE, 1'b0));
        // Restart keeps mode and shown frame.
        add_row(word_of(ACT_RESTART, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b1,
                state_of(8'hFF, 4'd0, MODE_NONE, 1'b0));
        add_row(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_LOOP), 1'b1,
                state_of(8'hFF, 4'd0, MODE_LOOP, 1'b0));
        // Loop ticks: no advance, exactly one advance, then a long walk.
        add_row(word_of(ACT_TICK, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_TICK, 16'h1000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_TICK, 16'hFFFF, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        // Once mode runs off the end of the active steps and stops.
        add_row(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_ONCE), 1'b0, '0);
        add_row(word_of(ACT_TICK, 16'hFFFF, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        // A zero duration step can never refill time, so the walk hits the cap.
        add_row(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_LOOP), 1'b0, '0);
        add_row(word_of(ACT_LOAD, 16'h0000, 4'h0, 8'h00, 8'hAA, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_TICK, 16'hFFFF, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_LOAD, 16'h0000, 4'h0, 8'h01, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_RESTART, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_SET_FRAME, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_ONCE), 1'b0, '0);
        add_row(word_of(ACT_TICK, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        add_row(word_of(ACT_SPARE_MID, 16'h5A5A, 4'hA, 8'h5A, 8'hA5, MODE_LOOP), 1'b0, '0);

        foreach (directed_rows[n])
            send_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].want);

        // Full table, unit speed.
        program_regs(16'd16, 16'd0, 16'h1000);
        no_idle = 1'b0;
        run_random_phase(300);

        // Step count zero acts as one; last restart slot; zero speed leaves every
        // reload empty, so the cap is hit on most playing ticks. No idling here.
        program_regs(16'd0, 16'd15, 16'd0);
        no_idle = 1'b1;
        run_random_phase(150);

        // Junk in the upper data bits: the count reads as 31 and acts as the table
        // size. The unused index is written too and must change nothing.
        program_regs(16'hFFFF, 16'hFFF5, 16'h1000);
        rnd = $urandom;
        write_cfg(CFG_NO_REG, rnd[15:0]);
        no_idle = 1'b0;
        run_random_phase(250);

        // Count just past the table size, full scale speed.
        program_regs(16'd17, 16'd15, 16'hFFFF);
        run_random_phase(200);

        // Random settings; the count often falls below the current step.
        for (int p = 0; p < 3; p++)
        begin
            program_regs(16'($urandom_range(1, 16)), 16'($urandom_range(0, 15)),
                         16'($urandom_range(16'h0800, 16'h3000)));
            no_idle = (p == 1);
            run_random_phase(250);
        end

        // Drive the remaining time into positive saturation with repeated restarts
        // of the longest step at full speed, then let it play. This comes last since
        // afterwards the time stays far above zero.
        program_regs(16'd16, 16'd2, 16'hFFFF);
        no_idle = 1'b0;
        send_word(word_of(ACT_LOAD, 16'h0000, 4'd2, 8'hFF, 8'h3C, MODE_NONE), 1'b0, '0);
        send_word(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_STOPPED),
                  1'b0, '0);
        for (int k = 0; k < 160; k++)
            send_word(word_of(ACT_RESTART, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE),
                      1'b0, '0);
        send_word(word_of(ACT_SET_MODE, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_LOOP), 1'b0, '0);
        for (int k = 0; k < 10; k++)
            send_word(word_of(ACT_TICK, 16'hFFFF, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        send_word(word_of(ACT_RESTART, 16'h0000, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);
        send_word(word_of(ACT_TICK, 16'h0001, 4'h0, 8'h00, 8'h00, MODE_NONE), 1'b0, '0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_sprite_frame_sequencer: clean");
        else
            $display("tb_sprite_frame_sequencer: errors");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/sfs_pkg.sv
hw/rtl/sfs_ram.sv
hw/rtl/sprite_frame_sequencer.sv
test/tb_sprite_frame_sequencer.sv
